[sv/cad_pkg.sv]
// Shared constants for the crop area-average luma downscaler.
`timescale 1ns / 1ps
package cad_pkg;

  localparam int DIM_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int FMT_W      = 2;
  localparam int PIX_W      = 32;

  localparam int OUT_WIDTH_DEF  = 96;
  localparam int OUT_HEIGHT_DEF = 96;
  localparam int MAX_LINE_DEF   = 2048;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  // Pixel formats; the unused code falls back to RGB565
  localparam logic [FMT_W-1:0] FMT_RGB565 = 2'd0;
  localparam logic [FMT_W-1:0] FMT_YUYV   = 2'd1;
  localparam logic [FMT_W-1:0] FMT_BGRX32 = 2'd2;

  localparam logic [FMT_W-1:0]      RST_FORMAT = FMT_RGB565;
  localparam logic [DIM_W-1:0]      RST_WIDTH  = 12'd320;
  localparam logic [DIM_W-1:0]      RST_HEIGHT = 12'd240;

  localparam logic [7:0] W_RED   = 8'd77;
  localparam logic [7:0] W_GREEN = 8'd150;
  localparam logic [7:0] W_BLUE  = 8'd29;

  localparam int EV_DEPTH = 4;

endpackage

[sv/cad_front.sv]
// Front end: config registers, crop setup, luma conversion, position tracking, row-run sums.
`timescale 1ns / 1ps
module cad_front import cad_pkg::*; #(
  parameter int OUT_WIDTH  = OUT_WIDTH_DEF,
  parameter int OUT_HEIGHT = OUT_HEIGHT_DEF,
  parameter int MAX_LINE   = MAX_LINE_DEF,
  parameter int EV_W       = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  pix_valid_i,
  output logic                  pix_ready_o,
  input  logic [PIX_W-1:0]      pix_word_i,
  input  logic                  pix_start_i,
  input  logic                  ev_full_i,
  output logic                  ev_push_o,
  output logic [EV_W-1:0]       ev_data_o
);

  localparam int XCW  = $clog2(OUT_WIDTH + 1);
  localparam int YCW  = $clog2(OUT_HEIGHT + 1);
  localparam int XW   = $clog2(OUT_WIDTH);
  localparam int YW   = $clog2(OUT_HEIGHT);
  localparam int BWW  = $clog2(MAX_LINE / OUT_WIDTH + 2);
  localparam int BHW  = $clog2(MAX_LINE / OUT_HEIGHT + 2);
  localparam int ACCW = 8 + BWW;
  localparam int RXW  = $clog2(OUT_WIDTH) + 1;
  localparam int RYW  = $clog2(OUT_HEIGHT) + 1;
  localparam int LO   = (OUT_WIDTH > OUT_HEIGHT) ? OUT_WIDTH : OUT_HEIGHT;
  localparam int EW   = DIM_W + 1;
  // reciprocals exact for every DIM_W-bit crop side
  localparam int RSW  = DIM_W + XW;
  localparam int RSH  = DIM_W + YW;
  localparam int PW   = 2 * DIM_W + 1;
  localparam logic [DIM_W:0] RCP_W = (DIM_W + 1)'(((1 << RSW) + OUT_WIDTH - 1) / OUT_WIDTH);
  localparam logic [DIM_W:0] RCP_H = (DIM_W + 1)'(((1 << RSH) + OUT_HEIGHT - 1) / OUT_HEIGHT);

  logic [FMT_W-1:0] fmt_q;
  logic [DIM_W-1:0] fw_q, fh_q;

  logic [DIM_W-1:0] sc_q, sr_q, nre_q, nce_q, cs_q;
  logic [YCW-1:0]   dr_q;
  logic [XCW-1:0]   dc_q;
  logic [BHW-1:0]   bc_q;
  logic [RYW-1:0]   rre_q;
  logic [RXW-1:0]   rce_q;
  logic [ACCW-1:0]  acc_q;
  logic [DIM_W-1:0] q0w_q, q0h_q;
  logic [RXW-1:0]   r0w_q;
  logic [RYW-1:0]   r0h_q;
  logic             setup_q, pend_q;

  logic [DIM_W-1:0] w_eff, h_eff, crop, x0;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [EW-1:0] ve;
    ve = {1'b0, v};
    if (ve < EW'(LO)) return DIM_W'(LO);
    else if (ve > EW'(MAX_LINE)) return DIM_W'(MAX_LINE);
    else return v;
  endfunction

  always_comb begin
    w_eff = clamp_dim(fw_q);
    h_eff = clamp_dim(fh_q);
    crop  = (h_eff < w_eff) ? h_eff : w_eff;
    x0    = (w_eff - crop) >> 1;
  end

  // Setup: crop / OUT_WIDTH and crop / OUT_HEIGHT by reciprocal multiply, plus remainders
  logic [PW-1:0]    pw, ph;
  logic [RXW-1:0]   nr_w;
  logic [RYW-1:0]   nr_h;
  logic [DIM_W-1:0] nq_w, nq_h;

  always_comb begin
    pw   = PW'(crop) * PW'(RCP_W);
    ph   = PW'(crop) * PW'(RCP_H);
    nq_w = DIM_W'(pw >> RSW);
    nq_h = DIM_W'(ph >> RSH);
    nr_w = RXW'(crop - DIM_W'(nq_w * DIM_W'(OUT_WIDTH)));
    nr_h = RYW'(crop - DIM_W'(nq_h * DIM_W'(OUT_HEIGHT)));
  end

  // Luma
  logic [7:0]  r8, g8, b8, luma;
  logic [17:0] lsum;

  always_comb begin
    b8 = pix_word_i[7:0];
    g8 = pix_word_i[15:8];
    r8 = pix_word_i[23:16];
    if (fmt_q != FMT_BGRX32) begin
      r8 = {pix_word_i[15:11], 3'b000};
      g8 = {pix_word_i[10:5], 2'b00};
      b8 = {pix_word_i[4:0], 3'b000};
    end
    lsum = 18'(r8 * W_RED) + 18'(g8 * W_GREEN) + 18'(b8 * W_BLUE);
    luma = (fmt_q == FMT_YUYV) ? pix_word_i[7:0] : lsum[15:8];
  end

  // Position tracking for one pixel
  logic accept, fs;
  logic [DIM_W-1:0] c_sc, c_sr, c_nre, c_nce, c_cs;
  logic [YCW-1:0]   c_dr;
  logic [XCW-1:0]   c_dc;
  logic [BHW-1:0]   c_bc;
  logic [RYW-1:0]   c_rre;
  logic [RXW-1:0]   c_rce;
  logic [ACCW-1:0]  c_acc, box_sum;
  logic [DIM_W-1:0] n_sc, n_sr, n_nre, n_nce, n_cs;
  logic [YCW-1:0]   n_dr;
  logic [XCW-1:0]   n_dc;
  logic [BHW-1:0]   n_bc;
  logic [RYW-1:0]   n_rre;
  logic [RXW-1:0]   n_rce;
  logic [ACCW-1:0]  n_acc;
  logic [RXW:0]     s_rc;
  logic [RYW:0]     s_rr;
  logic             wrap_c, wrap_r, inbox, hit, band, push;
  logic [BWW-1:0]   bw;
  logic [BHW-1:0]   bh;

  assign fs          = pix_start_i;
  assign pix_ready_o = !setup_q && !ev_full_i;
  assign accept      = pix_valid_i && pix_ready_o;

  always_comb begin
    c_sc  = fs ? '0 : sc_q;
    c_sr  = fs ? '0 : sr_q;
    c_dr  = fs ? '0 : dr_q;
    c_dc  = fs ? '0 : dc_q;
    c_bc  = fs ? '0 : bc_q;
    c_nre = fs ? q0h_q : nre_q;
    c_rre = fs ? r0h_q : rre_q;
    c_nce = fs ? q0w_q : nce_q;
    c_rce = fs ? r0w_q : rce_q;
    c_cs  = fs ? '0 : cs_q;
    c_acc = fs ? '0 : acc_q;

    s_rc   = {1'b0, c_rce} + {1'b0, r0w_q};
    wrap_c = (s_rc >= (RXW + 1)'(OUT_WIDTH));
    s_rr   = {1'b0, c_rre} + {1'b0, r0h_q};
    wrap_r = (s_rr >= (RYW + 1)'(OUT_HEIGHT));

    inbox = (c_dr < YCW'(OUT_HEIGHT)) && (c_dc < XCW'(OUT_WIDTH)) &&
            (c_sc >= x0) && ({1'b0, c_sc} < ({1'b0, x0} + {1'b0, crop}));
    hit   = ({1'b0, c_sc} + EW'(1)) == ({1'b0, c_nce} + {1'b0, x0});
    band  = ({1'b0, c_sr} + EW'(1)) == {1'b0, c_nre};
    box_sum = c_acc + ACCW'(luma);
    bw    = BWW'(c_nce - c_cs);
    bh    = BHW'(c_bc + BHW'(1));

    n_sc = c_sc; n_sr = c_sr; n_dr = c_dr; n_dc = c_dc; n_bc = c_bc;
    n_nre = c_nre; n_rre = c_rre; n_nce = c_nce; n_rce = c_rce;
    n_cs = c_cs; n_acc = c_acc;
    push = 1'b0;

    if (c_sr < h_eff) begin
      if (inbox) begin
        if (hit) begin
          push  = 1'b1;
          n_acc = '0;
          n_dc  = c_dc + XCW'(1);
          n_cs  = c_nce;
          n_nce = c_nce + q0w_q + DIM_W'(wrap_c);
          n_rce = wrap_c ? RXW'(s_rc - (RXW + 1)'(OUT_WIDTH)) : RXW'(s_rc);
        end else begin
          n_acc = box_sum;
        end
      end
      if (({1'b0, c_sc} + EW'(1)) >= {1'b0, w_eff}) begin
        n_sc  = '0;
        n_dc  = '0;
        n_nce = q0w_q;
        n_rce = r0w_q;
        n_cs  = '0;
        n_acc = '0;
        if (c_dr < YCW'(OUT_HEIGHT)) begin
          if (band) begin
            n_dr  = c_dr + YCW'(1);
            n_bc  = '0;
            n_nre = c_nre + q0h_q + DIM_W'(wrap_r);
            n_rre = wrap_r ? RYW'(s_rr - (RYW + 1)'(OUT_HEIGHT)) : RYW'(s_rr);
          end else begin
            n_bc = c_bc + BHW'(1);
          end
        end
        n_sr = c_sr + DIM_W'(1);
      end else begin
        n_sc = c_sc + DIM_W'(1);
      end
    end
  end

  assign ev_push_o = accept && push;
  // event: col, row, row-run sum, box width, box height, band end, clear sums
  assign ev_data_o = {(pend_q || fs), band, bh, bw, box_sum,
                      c_dr[YW-1:0], c_dc[XW-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q   <= RST_FORMAT;
      fw_q    <= RST_WIDTH;
      fh_q    <= RST_HEIGHT;
      setup_q <= 1'b1;
      q0w_q   <= '0;
      q0h_q   <= '0;
      r0w_q   <= '0;
      r0h_q   <= '0;
      pend_q  <= 1'b1;
      sc_q    <= '0;
      sr_q    <= '0;
      dr_q    <= '0;
      dc_q    <= '0;
      bc_q    <= '0;
      nre_q   <= '0;
      rre_q   <= '0;
      nce_q   <= '0;
      rce_q   <= '0;
      cs_q    <= '0;
      acc_q   <= '0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == REG_PIXEL_FORMAT || cfg_idx_i == REG_FRAME_WIDTH ||
                       cfg_idx_i == REG_FRAME_HEIGHT)) begin
        case (cfg_idx_i)
          REG_PIXEL_FORMAT: fmt_q <= cfg_data_i[FMT_W-1:0];
          REG_FRAME_WIDTH:  fw_q  <= cfg_data_i[DIM_W-1:0];
          REG_FRAME_HEIGHT: fh_q  <= cfg_data_i[DIM_W-1:0];
          default:          fmt_q <= fmt_q;
        endcase
        setup_q <= 1'b1;
      end else if (setup_q) begin
        // frame restart with the fresh edge steps
        setup_q <= 1'b0;
        q0w_q   <= nq_w;
        q0h_q   <= nq_h;
        r0w_q   <= nr_w;
        r0h_q   <= nr_h;
        pend_q  <= 1'b1;
        sc_q    <= '0;
        sr_q    <= '0;
        dr_q    <= '0;
        dc_q    <= '0;
        bc_q    <= '0;
        nre_q   <= nq_h;
        rre_q   <= nr_h;
        nce_q   <= nq_w;
        rce_q   <= nr_w;
        cs_q    <= '0;
        acc_q   <= '0;
      end else if (accept) begin
        sc_q  <= n_sc;
        sr_q  <= n_sr;
        dr_q  <= n_dr;
        dc_q  <= n_dc;
        bc_q  <= n_bc;
        nre_q <= n_nre;
        rre_q <= n_rre;
        nce_q <= n_nce;
        rce_q <= n_rce;
        cs_q  <= n_cs;
        acc_q <= n_acc;
        if (push) pend_q <= 1'b0;
        else if (fs) pend_q <= 1'b1;
      end
    end
  end

endmodule

[sv/cad_fifo.sv]
// Small event queue between the front and back ends.
`timescale 1ns / 1ps
module cad_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
      if (pop_i)  rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop_i);
    end
  end

endmodule

[sv/cad_back.sv]
// Back end: column sum memory, box area, serial divider and output register.
`timescale 1ns / 1ps
module cad_back import cad_pkg::*; #(
  parameter int OUT_WIDTH  = OUT_WIDTH_DEF,
  parameter int OUT_HEIGHT = OUT_HEIGHT_DEF,
  parameter int MAX_LINE   = MAX_LINE_DEF,
  parameter int EV_W       = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           ev_empty_i,
  input  logic [EV_W-1:0]                ev_data_i,
  output logic                           ev_pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     gray_o,
  output logic [$clog2(OUT_WIDTH)-1:0]   out_x_o,
  output logic [$clog2(OUT_HEIGHT)-1:0]  out_y_o,
  output logic                           frame_done_o
);

  localparam int XW    = $clog2(OUT_WIDTH);
  localparam int YW    = $clog2(OUT_HEIGHT);
  localparam int BWW   = $clog2(MAX_LINE / OUT_WIDTH + 2);
  localparam int BHW   = $clog2(MAX_LINE / OUT_HEIGHT + 2);
  localparam int ACCW  = 8 + BWW;
  localparam int AREAW = BWW + BHW;
  localparam int SUMW  = 8 + AREAW;
  localparam int DCW   = $clog2(SUMW + 1);

  typedef enum logic [1:0] {S_IDLE, S_ADD, S_DIV, S_OUT} state_e;

  state_e            state_q;
  logic [XW-1:0]     col_q;
  logic [YW-1:0]     row_q;
  logic              band_q;
  logic [ACCW-1:0]   run_q;
  logic [BWW-1:0]    bw_q;
  logic [BHW-1:0]    bh_q;
  logic [SUMW-1:0]   rd_q, quo_q;
  logic [AREAW-1:0]  area_q, rem_q;
  logic [DCW-1:0]    dcnt_q;
  logic [OUT_WIDTH-1:0] vld_q;
  logic [SUMW-1:0]   mem [OUT_WIDTH];

  // event fields, lowest first
  logic [XW-1:0]   e_col;
  logic [YW-1:0]   e_row;
  logic [ACCW-1:0] e_run;
  logic [BWW-1:0]  e_bw;
  logic [BHW-1:0]  e_bh;
  logic            e_band, e_clr;

  assign {e_clr, e_band, e_bh, e_bw, e_run, e_row, e_col} = ev_data_i;

  logic [SUMW-1:0]  tot;
  logic [AREAW:0]   trial;
  logic             qbit;
  logic             mem_we;

  always_comb begin
    tot    = (vld_q[col_q] ? rd_q : '0) + SUMW'(run_q);
    trial  = {rem_q, quo_q[SUMW-1]};
    qbit   = (trial >= {1'b0, area_q});
    mem_we = (state_q == S_ADD) && !band_q;
  end

  assign ev_pop_o     = (state_q == S_IDLE) && !ev_empty_i;
  assign out_valid_o  = (state_q == S_OUT);
  assign gray_o       = quo_q[7:0];
  assign out_x_o      = col_q;
  assign out_y_o      = row_q;
  assign frame_done_o = (col_q == XW'(OUT_WIDTH - 1)) && (row_q == YW'(OUT_HEIGHT - 1));

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[col_q] <= tot;
    rd_q <= mem[e_col];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vld_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
      band_q  <= 1'b0;
      run_q   <= '0;
      bw_q    <= '0;
      bh_q    <= '0;
      quo_q   <= '0;
      area_q  <= '0;
      rem_q   <= '0;
      dcnt_q  <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (!ev_empty_i) begin
            if (e_clr) vld_q <= '0;
            col_q   <= e_col;
            row_q   <= e_row;
            band_q  <= e_band;
            run_q   <= e_run;
            bw_q    <= e_bw;
            bh_q    <= e_bh;
            state_q <= S_ADD;
          end
        end
        S_ADD: begin
          if (band_q) begin
            // box done: its sum leaves, the column starts over
            vld_q[col_q] <= 1'b0;
            quo_q   <= tot;
            area_q  <= AREAW'(bw_q * bh_q);
            rem_q   <= '0;
            dcnt_q  <= '0;
            state_q <= S_DIV;
          end else begin
            vld_q[col_q] <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_DIV: begin
          rem_q  <= qbit ? AREAW'(trial - {1'b0, area_q}) : AREAW'(trial);
          quo_q  <= {quo_q[SUMW-2:0], qbit};
          dcnt_q <= dcnt_q + DCW'(1);
          if (dcnt_q == DCW'(SUMW - 1)) state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/crop_area_average_luma_downscaler.sv]
// Throughput: one pixel per cycle while the event queue has room and no crop setup runs. Each
// box-row end passes through the back end's column sum memory port; each finished box also runs
// the serial divider over SUMW quotient bits (SUMW = 8 + box width bits + box height bits, 18
// at the defaults) before its result is offered.
// Reset (async, low) and every register write run a crop step setup with s_axis_tready low,
// then restart the frame position and treat all column sums as zero.
`timescale 1ns / 1ps
module crop_area_average_luma_downscaler import cad_pkg::*; #(
  parameter int OUT_WIDTH  = OUT_WIDTH_DEF,
  parameter int OUT_HEIGHT = OUT_HEIGHT_DEF,
  parameter int MAX_LINE   = MAX_LINE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [PIX_W-1:0]      s_axis_tdata,   // pixel_word
  input  logic                  s_axis_tuser,   // frame_start
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // gray, out_x, out_y, zero fill
  output logic [((8 + $clog2(OUT_WIDTH) + $clog2(OUT_HEIGHT) + 7) / 8) * 8 - 1:0] m_axis_tdata,
  output logic                  m_axis_tlast    // frame_done
);

  localparam int XW    = $clog2(OUT_WIDTH);
  localparam int YW    = $clog2(OUT_HEIGHT);
  localparam int BWW   = $clog2(MAX_LINE / OUT_WIDTH + 2);
  localparam int BHW   = $clog2(MAX_LINE / OUT_HEIGHT + 2);
  localparam int ACCW  = 8 + BWW;
  localparam int EV_W  = XW + YW + ACCW + BWW + BHW + 2;
  localparam int OD_W  = 8 + XW + YW;
  localparam int TD_W  = ((OD_W + 7) / 8) * 8;

  logic            ev_push, ev_full, ev_pop, ev_empty;
  logic [EV_W-1:0] ev_wdata, ev_rdata;
  logic [7:0]      gray;
  logic [XW-1:0]   out_x;
  logic [YW-1:0]   out_y;

  cad_front #(
    .OUT_WIDTH(OUT_WIDTH), .OUT_HEIGHT(OUT_HEIGHT), .MAX_LINE(MAX_LINE), .EV_W(EV_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .pix_valid_i (s_axis_tvalid),
    .pix_ready_o (s_axis_tready),
    .pix_word_i  (s_axis_tdata),
    .pix_start_i (s_axis_tuser),
    .ev_full_i   (ev_full),
    .ev_push_o   (ev_push),
    .ev_data_o   (ev_wdata)
  );

  cad_fifo #(.W(EV_W), .DEPTH(EV_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ev_push),
    .data_i  (ev_wdata),
    .full_o  (ev_full),
    .pop_i   (ev_pop),
    .data_o  (ev_rdata),
    .empty_o (ev_empty)
  );

  cad_back #(
    .OUT_WIDTH(OUT_WIDTH), .OUT_HEIGHT(OUT_HEIGHT), .MAX_LINE(MAX_LINE), .EV_W(EV_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ev_empty_i   (ev_empty),
    .ev_data_i    (ev_rdata),
    .ev_pop_o     (ev_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .gray_o       (gray),
    .out_x_o      (out_x),
    .out_y_o      (out_y),
    .frame_done_o (m_axis_tlast)
  );

  assign m_axis_tdata = TD_W'({out_y, out_x, gray});

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_push |-> !ev_full)
    else $error("event pushed into a full queue");

  a_cfg_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && (cfg_idx_i == REG_PIXEL_FORMAT || cfg_idx_i == REG_FRAME_WIDTH ||
                  cfg_idx_i == REG_FRAME_HEIGHT)) |=> !s_axis_tready)
    else $error("pixel taken during crop setup");

  a_last_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |->
      (out_x == XW'(OUT_WIDTH - 1) && out_y == YW'(OUT_HEIGHT - 1)))
    else $error("frame end flagged off the last box");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_pop |-> !ev_empty && !m_axis_tvalid)
    else $error("back end popped while busy or queue empty");

endmodule

[bench/crop_area_average_luma_downscaler_tb.sv]
// Self-checking testbench for the crop area-average luma downscaler.
`timescale 1ns / 1ps
module crop_area_average_luma_downscaler_tb;
  import cad_pkg::*;

  localparam int NOUT      = 96;
  localparam int TD_W      = 24;
  localparam int RAND_GOAL = 550;
  localparam int HOLD_LEN  = 4000;
  localparam int SETTLE    = 200;
  localparam int LIMIT     = 4000000;

  typedef struct packed {
    logic [7:0] gray;
    logic [6:0] ox;
    logic [6:0] oy;
    logic       done;
  } box_avg_t;

  class luma_box_scoreboard;
    logic [FMT_W-1:0] fmt;
    logic [DIM_W-1:0] fw, fh;
    int unsigned sums[NOUT];
    int unsigned scol, srow, drow, dcol, nre, nce, brc;
    box_avg_t    box_q[$];
    int          errors, results, frames;

    function new();
      fmt = RST_FORMAT; fw = RST_WIDTH; fh = RST_HEIGHT;
      errors = 0; results = 0; frames = 0;
      restart();
    endfunction

    function int unsigned clamp(int unsigned v);
      if (v < NOUT) return NOUT;
      if (v > MAX_LINE_DEF) return MAX_LINE_DEF;
      return v;
    endfunction

    function int unsigned crop();
      int unsigned w, h;
      w = clamp(32'(fw)); h = clamp(32'(fh));
      return (h < w) ? h : w;
    endfunction

    function int unsigned luma(logic [31:0] px);
      int unsigned r, g, b;
      if (fmt == FMT_YUYV) return 32'(px[7:0]);
      if (fmt == FMT_BGRX32) begin
        b = 32'(px[7:0]); g = 32'(px[15:8]); r = 32'(px[23:16]);
      end else begin
        r = 32'(px[15:11]) << 3; g = 32'(px[10:5]) << 2; b = 32'(px[4:0]) << 3;
      end
      return ((r * 77 + g * 150 + b * 29) >> 8) & 8'hFF;
    endfunction

    function void restart();
      int unsigned c;
      c = crop();
      foreach (sums[i]) sums[i] = 0;
      scol = 0; srow = 0; drow = 0; dcol = 0; brc = 0;
      nre = c / NOUT; nce = c / NOUT;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_PIXEL_FORMAT: fmt = val[FMT_W-1:0];
        REG_FRAME_WIDTH:  fw = val;
        REG_FRAME_HEIGHT: fh = val;
        default: return;
      endcase
      restart();
    endfunction

    function void note_pixel(logic [31:0] px, logic fs);
      int unsigned w, h, c, x0, cx, cs, area;
      box_avg_t e;
      if (fs) restart();
      w = clamp(32'(fw)); h = clamp(32'(fh)); c = crop(); x0 = (w - c) / 2;
      if (srow >= h) return;  // past the last row: ignored
      if (drow < NOUT && dcol < NOUT && scol >= x0 && scol < x0 + c) begin
        cx = scol - x0;
        sums[dcol] += luma(px);
        if (cx + 1 == nce) begin
          if (srow + 1 == nre) begin
            cs = dcol * c / NOUT;
            area = (nce - cs) * (brc + 1);
            e.gray = 8'((area != 0) ? sums[dcol] / area : 0);
            e.ox = 7'(dcol); e.oy = 7'(drow);
            e.done = (dcol == NOUT - 1 && drow == NOUT - 1);
            box_q.push_back(e);
            sums[dcol] = 0;
          end
          dcol++;
          if (dcol < NOUT) nce = (dcol + 1) * c / NOUT;
        end
      end
      scol++;
      if (scol >= w) begin
        scol = 0; dcol = 0; nce = c / NOUT;
        if (drow < NOUT) begin
          if (srow + 1 == nre) begin
            drow++; brc = 0;
            if (drow < NOUT) nre = (drow + 1) * c / NOUT;
          end else begin
            brc++;
          end
        end
        srow++;
      end
    endfunction

    function void check_result(logic [TD_W-1:0] d, logic last);
      box_avg_t e, a;
      a.gray = d[7:0]; a.ox = d[14:8]; a.oy = d[21:15]; a.done = last;
      results++;
      if (last) frames++;
      if (box_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected beat: gray %0d x %0d y %0d last %0d",
                   a.gray, a.ox, a.oy, a.done);
        return;
      end
      e = box_q.pop_front();
      if (a !== e || d[TD_W-1:22] !== '0) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp gray %0d x %0d y %0d last %0d, got %0d %0d %0d %0d",
                   e.gray, e.ox, e.oy, e.done, a.gray, a.ox, a.oy, a.done);
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [PIX_W-1:0]      s_axis_tdata = '0;   // pixel_word
  logic                  s_axis_tuser = 1'b0; // frame_start
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [TD_W-1:0]       m_axis_tdata;        // gray, out_x, out_y, zero fill
  logic                  m_axis_tlast;        // frame_done

  crop_area_average_luma_downscaler u_top (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  luma_box_scoreboard sb = new();
  bit  calm = 0, hold_req = 0;
  int  cycles = 0, pixels = 0, reg_writes = 0;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // sink: ready bursts and one long hold-off
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_LEN - 1) @(posedge clk_i);
        hold_req = 0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // output beats are sampled mid-cycle and taken at the following edge
  logic            out_fire;
  logic [TD_W-1:0] out_data;
  logic            out_last;
  always @(negedge clk_i) begin
    out_fire = m_axis_tvalid && m_axis_tready;
    out_data = m_axis_tdata;
    out_last = m_axis_tlast;
  end
  always @(posedge clk_i) if (rst_ni && out_fire) sb.check_result(out_data, out_last);

  task automatic send_pixel(logic [31:0] px, logic fs);
    bit rdy;
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    s_axis_tuser  <= fs;
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
    sb.note_pixel(px, fs);
    pixels++;
  endtask

  task automatic go_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.box_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // the write enable stays high across back-to-back writes; configure drops it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    reg_writes++;
  endtask

  task automatic configure(logic [1:0] f, logic [11:0] w, logic [11:0] h);
    go_idle();
    write_reg(REG_PIXEL_FORMAT, CFG_DATA_W'(f));
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_pixel();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int unsigned w, h, n, start;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config 320x240: crop margins, then extreme words
    send_pixel(32'hFFFF_FFFF, 1'b0);
    for (int i = 0; i < 60; i++) send_pixel(i[0] ? 32'h0 : 32'hFFFF_FFFF, i == 0);
    send_pixel(32'h0000_F800, 1'b0);
    send_pixel(32'h0000_07E0, 1'b0);
    send_pixel(32'h0000_001F, 1'b0);
    send_pixel(32'hA5A5_5A5A, 1'b1);

    // first rows of a 96x96 frame, one result per pixel, under a long output hold-off
    configure(FMT_BGRX32, 12'd96, 12'd96);
    for (int i = 0; i < 500; i++) begin
      if (i == 200) hold_req = 1;
      send_pixel(rand_pixel(), i == 0);
    end

    // clamps: tiny and oversized dimensions, height above width, unused format
    configure(2'd3, 12'd0, 12'd4095);
    for (int i = 0; i < 100; i++) send_pixel(rand_pixel(), 1'b0);

    start = pixels;
    while (pixels - start < RAND_GOAL) begin
      if (pixels - start > RAND_GOAL * 3 / 4) calm = 1;
      case ($urandom_range(0, 9))
        0: w = 2048;
        1: w = $urandom_range(0, 4095);
        default: w = $urandom_range(96, 160);
      endcase
      h = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095) : $urandom_range(96, 130);
      configure(2'($urandom_range(0, 3)), 12'(w), 12'(h));
      n = $urandom_range(60, 260);
      for (int i = 0; i < n; i++)
        send_pixel(rand_pixel(),
                   i == 0 ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 80) == 0));
    end

    go_idle();
    $display("%0d pixels, %0d register writes, %0d box averages, %0d frames completed",
             pixels, reg_writes, sb.results, sb.frames);
    $display("%0d mismatches, %0d averages still owed", sb.errors, sb.box_q.size());
    if (sb.errors == 0 && sb.box_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
sv/cad_pkg.sv
sv/cad_front.sv
sv/cad_fifo.sv
sv/cad_back.sv
sv/crop_area_average_luma_downscaler.sv
bench/crop_area_average_luma_downscaler_tb.sv
